// ===== design/dmtr_pkg.sv =====
// shared constants, codes and stipple table of the depth map triangle rasterizer
package dmtr_pkg;

    localparam int MAP_SIZE_DEFAULT = 256;

    localparam int XYW  = 24;
    localparam int ZW   = 18;
    localparam int EW   = 25;
    localparam int MW   = 27;
    localparam int PW   = 54;
    localparam int WW   = 52;
    localparam int NW   = 72;
    localparam int AREW = 51;
    localparam int UAW  = 50;
    localparam int QW   = 84;
    localparam int BW   = 18;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] CFG_TILE_X_FIRST  = 3'd0;
    localparam logic [2:0] CFG_TILE_X_LAST   = 3'd1;
    localparam logic [2:0] CFG_STRIP_Y_FIRST = 3'd2;
    localparam logic [2:0] CFG_STRIP_Y_LAST  = 3'd3;
    localparam logic [2:0] CFG_CLEAR_DEPTH   = 3'd4;

    localparam logic [UAW-1:0] MIN_AREA = UAW'(7);

    function automatic logic [15:0] stipple_pattern(input logic [2:0] sel);
        logic [15:0] pat;
        unique case (sel)
            3'd0: pat = 16'hA5A5;
            3'd1: pat = 16'h5A5A;
            3'd2: pat = 16'h5555;
            3'd3: pat = 16'hAAAA;
            3'd4: pat = 16'h0F0F;
            3'd5: pat = 16'hF0F0;
            3'd6: pat = 16'h3C3C;
            3'd7: pat = 16'hC3C3;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/depth_map_triangle_rasterizer.sv =====
// depth map triangle rasterizer: sequencer, shared multiplier, divider and depth memory
//
// channel  | signals                                  | direction
// input    | i_in_valid, o_in_stall, i_command..      | in
// result   | o_out_valid, i_out_stall, o_read_depth.. | out
// config   | i_cfg_valid, o_cfg_ready, index, data    | in
//
// draw: accept, setup and done around the pixel loop; per box pixel the edge weights, then
// outside or masked pixels go on, depth out of range goes on after the numerator, else it is
// divided and tested against the map (one shared 27x27 multiplier, 16-step restoring divide)
// read: registered memory read; clear: all MAP_SIZE*MAP_SIZE entries, one memory entry per cycle
// synchronous active-low reset; map contents undefined until a clear
// input stalls while an item is in work; result register decouples the output
module depth_map_triangle_rasterizer
    import dmtr_pkg::*;
#(
    parameter int MAP_SIZE = MAP_SIZE_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  logic signed [XYW-1:0] i_v0_x,
    input  logic signed [XYW-1:0] i_v0_y,
    input  logic signed [ZW-1:0]  i_v0_z,
    input  logic signed [XYW-1:0] i_v1_x,
    input  logic signed [XYW-1:0] i_v1_y,
    input  logic signed [ZW-1:0]  i_v1_z,
    input  logic signed [XYW-1:0] i_v2_x,
    input  logic signed [XYW-1:0] i_v2_y,
    input  logic signed [ZW-1:0]  i_v2_z,
    input  logic [3:0]            i_stipple_select,
    input  logic [15:0]           i_pixel_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_read_depth,
    output logic [16:0]           o_pixels_updated,
    output logic                  o_culled,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int CW    = $clog2(MAP_SIZE);
    localparam int AW    = $clog2(DEPTH);
    localparam int PAW   = 2 * CW;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_SETUP = 18'h00002,
        S_BOX   = 18'h00004,
        S_AREA  = 18'h00008,
        S_CHECK = 18'h00010,
        S_EDGE  = 18'h00020,
        S_TEST  = 18'h00040,
        S_NUM   = 18'h00080,
        S_RANGE = 18'h00100,
        S_SCALE = 18'h00200,
        S_ROUND = 18'h00400,
        S_DIV   = 18'h00800,
        S_WR    = 18'h01000,
        S_NEXT  = 18'h02000,
        S_CLEAR = 18'h04000,
        S_READ  = 18'h08000,
        S_READ2 = 18'h10000,
        S_DONE  = 18'h20000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_tile_x_first, r_tile_x_last, r_strip_y_first, r_strip_y_last;
    logic [15:0] r_clear_depth;

    logic [1:0]            r_cmd;
    logic signed [XYW-1:0] r_vx [3];
    logic signed [XYW-1:0] r_vy [3];
    logic signed [ZW-1:0]  r_vz [3];
    logic [3:0]            r_sel;
    logic [15:0]           r_pix_idx;

    logic signed [XYW-1:0] r_xmn, r_xmx, r_ymn, r_ymx;
    logic signed [EW-1:0]  r_ea [3];
    logic signed [EW-1:0]  r_eb [3];
    logic signed [BW-1:0]  r_bx0, r_bx1, r_by0, r_by1;
    logic signed [PW-1:0]  r_prod;
    logic signed [AREW-1:0] r_area;
    logic signed [AREW-1:0] r_area_acc;
    logic [UAW-1:0]        r_uarea;
    logic signed [WW-1:0]  r_wacc;
    logic signed [WW-1:0]  r_w [3];
    logic [NW-1:0]         r_n;
    logic [QW-1:0]         r_q, r_d;
    logic [15:0]           r_zq;
    logic [2:0]            r_step;
    logic [3:0]            r_bit;
    logic [CW-1:0]         r_x, r_y;
    logic [16:0]           r_count;
    logic [AW-1:0]         r_clr;
    logic [15:0]           r_mem_rd;
    logic [15:0]           r_res_read;
    logic                  r_res_culled;

    logic        r_out_valid;
    logic [15:0] r_out_read;
    logic [16:0] r_out_count;
    logic        r_out_culled;

    logic [15:0] mem [0:DEPTH-1];

    logic in_acc, out_free, mem_we, in_range, px_in, stip_ok, cull, finish_px;
    logic [AW-1:0] rd_addr, wr_addr, pix_addr;
    logic [PAW-1:0] pix_addr_w;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [MW-1:0] px_u, py_u;
    logic [1:0] op_i, acc_i;
    logic [2:0] prev_step;
    logic [UAW-1:0] uarea_c;
    logic signed [AREW-1:0] neg_area;
    logic signed [BW-1:0] n_bx0, n_bx1, n_by0, n_by1;
    logic [QW-1:0] round_sum;
    logic [15:0] pat;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_read_depth     = r_out_read;
    assign o_pixels_updated = r_out_count;
    assign o_culled         = r_out_culled;

    // pixel and memory addressing
    assign pix_addr_w = PAW'(r_y) * PAW'(MAP_SIZE) + PAW'(r_x);
    assign pix_addr   = AW'(pix_addr_w);
    assign rd_addr    = (r_state == S_READ) ? AW'(r_pix_idx) : pix_addr;
    assign wr_addr    = (r_state == S_CLEAR) ? r_clr : pix_addr;
    assign mem_we     = (r_state == S_CLEAR) || ((r_state == S_WR) && (r_zq < r_mem_rd));
    assign in_range   = (25'(r_pix_idx) < 25'(DEPTH));

    assign px_u = MW'({r_x, 8'h80});
    assign py_u = MW'({r_y, 8'h80});

    assign op_i      = r_step[2:1];
    assign prev_step = r_step - 3'd1;
    assign acc_i     = prev_step[2:1];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_AREA: begin
                if (r_step == 3'd0) begin
                    mul_a = MW'(r_eb[2]);
                    mul_b = MW'(r_ea[1]);
                end else begin
                    mul_a = MW'(r_ea[2]);
                    mul_b = MW'(r_eb[1]);
                end
            end
            S_EDGE: begin
                case (op_i)
                    2'd0: begin
                        mul_a = r_step[0] ? MW'(r_eb[0]) : MW'(r_ea[0]);
                        mul_b = r_step[0] ? ($signed(py_u) - MW'(r_vy[2]))
                                          : ($signed(px_u) - MW'(r_vx[2]));
                    end
                    2'd1: begin
                        mul_a = r_step[0] ? MW'(r_eb[1]) : MW'(r_ea[1]);
                        mul_b = r_step[0] ? ($signed(py_u) - MW'(r_vy[0]))
                                          : ($signed(px_u) - MW'(r_vx[0]));
                    end
                    2'd2: begin
                        mul_a = r_step[0] ? MW'(r_eb[2]) : MW'(r_ea[2]);
                        mul_b = r_step[0] ? ($signed(py_u) - MW'(r_vy[1]))
                                          : ($signed(px_u) - MW'(r_vx[1]));
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_NUM: begin
                case (op_i)
                    2'd0: begin
                        mul_a = MW'(r_vz[0]);
                        mul_b = r_step[0] ? MW'($signed(r_w[0][WW-1:26]))
                                          : $signed({1'b0, r_w[0][25:0]});
                    end
                    2'd1: begin
                        mul_a = MW'(r_vz[1]);
                        mul_b = r_step[0] ? MW'($signed(r_w[1][WW-1:26]))
                                          : $signed({1'b0, r_w[1][25:0]});
                    end
                    2'd2: begin
                        mul_a = MW'(r_vz[2]);
                        mul_b = r_step[0] ? MW'($signed(r_w[2][WW-1:26]))
                                          : $signed({1'b0, r_w[2][25:0]});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // bounding box clamp
    always_comb begin
        logic signed [BW-1:0] lo_x, lo_y, hi_x, hi_y;
        logic signed [EW-1:0] mxr, myr;
        lo_x = r_xmn[XYW-1] ? BW'(0) : BW'(r_xmn >>> 8);
        lo_y = r_ymn[XYW-1] ? BW'(0) : BW'(r_ymn >>> 8);
        mxr  = EW'(r_xmx) + EW'(255);
        myr  = EW'(r_ymx) + EW'(255);
        hi_x = (r_xmx <= -XYW'(256)) ? -BW'(1) : BW'(mxr >>> 8);
        hi_y = (r_ymx <= -XYW'(256)) ? -BW'(1) : BW'(myr >>> 8);
        if (hi_x > BW'(MAP_SIZE - 1)) hi_x = BW'(MAP_SIZE - 1);
        if (hi_y > BW'(MAP_SIZE - 1)) hi_y = BW'(MAP_SIZE - 1);
        n_bx0 = (lo_x < $signed(BW'(r_tile_x_first))) ? $signed(BW'(r_tile_x_first)) : lo_x;
        n_by0 = (lo_y < $signed(BW'(r_strip_y_first))) ? $signed(BW'(r_strip_y_first)) : lo_y;
        n_bx1 = (hi_x > $signed(BW'(r_tile_x_last))) ? $signed(BW'(r_tile_x_last)) : hi_x;
        n_by1 = (hi_y > $signed(BW'(r_strip_y_last))) ? $signed(BW'(r_strip_y_last)) : hi_y;
    end

    assign neg_area  = -r_area;
    assign uarea_c   = r_area[AREW-1] ? UAW'(neg_area) : UAW'(r_area);
    assign cull      = (r_bx0 > r_bx1) || (r_by0 > r_by1) || (uarea_c < MIN_AREA);
    assign px_in     = !r_w[0][WW-1] && !r_w[1][WW-1] && !r_w[2][WW-1];
    assign pat       = stipple_pattern(3'(r_sel - 4'd1));
    assign stip_ok   = (r_sel == 4'd0) || pat[{2'(r_y), 2'(r_x)}];
    assign round_sum = r_q + {19'b0, r_uarea, 15'b0};
    assign finish_px = (CW'(r_bx1) == r_x) && (CW'(r_by1) == r_y);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_DRAW:  n_state = S_SETUP;
                        CMD_READ:  n_state = S_READ;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: n_state = S_BOX;
            S_BOX:   n_state = S_AREA;
            S_AREA:  if (r_step == 3'd2) n_state = S_CHECK;
            S_CHECK: n_state = cull ? S_DONE : S_EDGE;
            S_EDGE:  if (r_step == 3'd6) n_state = S_TEST;
            S_TEST:  n_state = (px_in && stip_ok) ? S_NUM : S_NEXT;
            S_NUM:   if (r_step == 3'd6) n_state = S_RANGE;
            S_RANGE: begin
                if (r_n[NW-1] || (r_n > {6'b0, r_uarea, 16'b0})) n_state = S_NEXT;
                else n_state = S_SCALE;
            end
            S_SCALE: n_state = S_ROUND;
            S_ROUND: n_state = S_DIV;
            S_DIV:   if (r_bit == 4'd0) n_state = S_WR;
            S_WR:    n_state = S_NEXT;
            S_NEXT:  n_state = finish_px ? S_DONE : S_EDGE;
            S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = S_DONE;
            S_READ:  n_state = S_READ2;
            S_READ2: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_tile_x_first  <= 8'd0;
            r_tile_x_last   <= 8'd255;
            r_strip_y_first <= 8'd0;
            r_strip_y_last  <= 8'd255;
            r_clear_depth   <= 16'hFFFF;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TILE_X_FIRST:  r_tile_x_first  <= i_cfg_data[7:0];
                    CFG_TILE_X_LAST:   r_tile_x_last   <= i_cfg_data[7:0];
                    CFG_STRIP_Y_FIRST: r_strip_y_first <= i_cfg_data[7:0];
                    CFG_STRIP_Y_LAST:  r_strip_y_last  <= i_cfg_data[7:0];
                    CFG_CLEAR_DEPTH:   r_clear_depth   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // depth memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= (r_state == S_CLEAR) ? r_clear_depth : r_zq;
        end
        r_mem_rd <= mem[rd_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                r_cmd        <= i_command;
                r_vx[0]      <= i_v0_x;
                r_vy[0]      <= i_v0_y;
                r_vz[0]      <= i_v0_z;
                r_vx[1]      <= i_v1_x;
                r_vy[1]      <= i_v1_y;
                r_vz[1]      <= i_v1_z;
                r_vx[2]      <= i_v2_x;
                r_vy[2]      <= i_v2_y;
                r_vz[2]      <= i_v2_z;
                r_sel        <= i_stipple_select;
                r_pix_idx    <= i_pixel_index;
                r_res_read   <= '0;
                r_res_culled <= 1'b0;
                r_count      <= '0;
                r_clr        <= '0;
                r_step       <= '0;
            end
            S_SETUP: begin
                r_xmn <= (r_vx[0] < r_vx[1]) ? ((r_vx[0] < r_vx[2]) ? r_vx[0] : r_vx[2])
                                             : ((r_vx[1] < r_vx[2]) ? r_vx[1] : r_vx[2]);
                r_xmx <= (r_vx[0] > r_vx[1]) ? ((r_vx[0] > r_vx[2]) ? r_vx[0] : r_vx[2])
                                             : ((r_vx[1] > r_vx[2]) ? r_vx[1] : r_vx[2]);
                r_ymn <= (r_vy[0] < r_vy[1]) ? ((r_vy[0] < r_vy[2]) ? r_vy[0] : r_vy[2])
                                             : ((r_vy[1] < r_vy[2]) ? r_vy[1] : r_vy[2]);
                r_ymx <= (r_vy[0] > r_vy[1]) ? ((r_vy[0] > r_vy[2]) ? r_vy[0] : r_vy[2])
                                             : ((r_vy[1] > r_vy[2]) ? r_vy[1] : r_vy[2]);
                r_ea[0] <= EW'(r_vy[2]) - EW'(r_vy[1]);
                r_eb[0] <= EW'(r_vx[1]) - EW'(r_vx[2]);
                r_ea[1] <= EW'(r_vy[0]) - EW'(r_vy[2]);
                r_eb[1] <= EW'(r_vx[2]) - EW'(r_vx[0]);
                r_ea[2] <= EW'(r_vy[1]) - EW'(r_vy[0]);
                r_eb[2] <= EW'(r_vx[0]) - EW'(r_vx[1]);
            end
            S_BOX: begin
                r_bx0  <= n_bx0;
                r_bx1  <= n_bx1;
                r_by0  <= n_by0;
                r_by1  <= n_by1;
                r_step <= '0;
            end
            S_AREA: begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd1) r_area_acc <= AREW'(r_prod);
                if (r_step == 3'd2) r_area <= r_area_acc - AREW'(r_prod);
            end
            S_CHECK: begin
                r_uarea <= uarea_c;
                if (cull) begin
                    r_res_culled <= 1'b1;
                end else if (!r_area[AREW-1] && (r_area != '0)) begin
                    // clockwise winding: flip all edges
                    r_ea[0] <= -r_ea[0];
                    r_ea[1] <= -r_ea[1];
                    r_ea[2] <= -r_ea[2];
                    r_eb[0] <= -r_eb[0];
                    r_eb[1] <= -r_eb[1];
                    r_eb[2] <= -r_eb[2];
                end
                r_x    <= CW'(r_bx0);
                r_y    <= CW'(r_by0);
                r_step <= '0;
            end
            S_EDGE: begin
                r_step <= r_step + 3'd1;
                if (r_step != 3'd0) begin
                    if (!prev_step[0]) begin
                        r_wacc <= WW'(r_prod);
                    end else begin
                        case (acc_i)
                            2'd0: r_w[0] <= r_wacc + WW'(r_prod);
                            2'd1: r_w[1] <= r_wacc + WW'(r_prod);
                            2'd2: r_w[2] <= r_wacc + WW'(r_prod);
                            default: ;
                        endcase
                    end
                end
            end
            S_TEST: begin
                r_n    <= '0;
                r_step <= '0;
            end
            S_NUM: begin
                r_step <= r_step + 3'd1;
                if (r_step != 3'd0) begin
                    if (!prev_step[0]) r_n <= r_n + NW'(r_prod);
                    else r_n <= r_n + (NW'(r_prod) << 26);
                end
            end
            S_RANGE: ;
            S_SCALE: begin
                r_q <= {r_n[QW-17:0], 16'b0} - QW'(r_n);
            end
            S_ROUND: begin
                r_q   <= {16'b0, round_sum[QW-1:16]};
                r_d   <= {19'b0, r_uarea, 15'b0};
                r_bit <= 4'd15;
                r_zq  <= '0;
            end
            S_DIV: begin
                if (r_q >= r_d) begin
                    r_q  <= r_q - r_d;
                    r_zq <= {r_zq[14:0], 1'b1};
                end else begin
                    r_zq <= {r_zq[14:0], 1'b0};
                end
                r_d   <= r_d >> 1;
                r_bit <= r_bit - 4'd1;
            end
            S_WR: begin
                if (r_zq < r_mem_rd) r_count <= r_count + 17'd1;
            end
            S_NEXT: begin
                r_step <= '0;
                if (r_x == CW'(r_bx1)) begin
                    r_x <= CW'(r_bx0);
                    if (r_y != CW'(r_by1)) r_y <= r_y + CW'(1);
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
            S_CLEAR: r_clr <= r_clr + AW'(1);
            S_READ: ;
            S_READ2: begin
                r_res_read <= in_range ? r_mem_rd : 16'd0;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_read   <= r_res_read;
                    r_out_count  <= r_count;
                    r_out_culled <= r_res_culled;
                end
            end
            default: ;
        endcase
    end

    a_culled_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_culled) |-> (o_pixels_updated == 17'd0 && o_read_depth == 16'd0))
        else $error("culled draw reports updates");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_READ) |=> (r_state == S_READ))
        else $error("read command did not enter read path");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without finishing an item");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && mem_we) |-> (r_res_culled == 1'b0 && r_cmd == CMD_DRAW))
        else $error("depth write outside a draw");

endmodule
